### sv/ptd_pkg.sv
// ptd_pkg: shared types, action codes and helpers for the periodic task dispatcher.
// No dependencies; imported by the interfaces, the slot cell and the top level.
`default_nettype none

package ptd_pkg;

	localparam int MAX_TASKS     = 32;
	localparam int DEF_TASKS     = 8;
	localparam int ACTION_W      = 2;
	localparam int INDEX_W       = 3;
	localparam int BYTE_W        = 8;
	localparam int DIV_W         = 16;
	localparam int COUNT_W       = 4;
	localparam int SUM_W         = $clog2(MAX_TASKS + 1);
	localparam int INDEX_SLOTS   = 1 << INDEX_W;

	localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DISPATCH = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_LOAD     = 2'd2;

	localparam logic [DIV_W-1:0]   DIV_RESET     = 16'd1;
	localparam logic [COUNT_W-1:0] COUNT_SAT     = 4'd15;

	// command broadcast to every slot cell in the accept cycle
	typedef struct packed {
		logic              fire;      // scheduler period elapsed on this tick
		logic              dispatch;  // dispatch item accepted
		logic              enable;    // load payload
		logic [BYTE_W-1:0] period;
		logic [BYTE_W-1:0] delay;
	} ptd_cmd_t;

	// number of ready marks, saturated to the 4-bit result field
	function automatic logic [COUNT_W-1:0] ready_sum(input logic [MAX_TASKS-1:0] marks);
		logic [SUM_W-1:0] n;
		n = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			n = n + SUM_W'(marks[i]);
		end
		if (n > SUM_W'(COUNT_SAT)) begin
			return COUNT_SAT;
		end
		return n[COUNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

### sv/ptd_if.sv
// ptd_if: valid/ready channel interfaces for request and result items.
// Depends on ptd_pkg for field widths.
`default_nettype none

interface ptd_req_if
	import ptd_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [INDEX_W-1:0]  task_index;
	logic                task_enable;
	logic [BYTE_W-1:0]   task_period;
	logic [BYTE_W-1:0]   start_delay;

	modport source (output valid, action, task_index, task_enable, task_period,
		start_delay, input ready);
	modport sink (input valid, action, task_index, task_enable, task_period,
		start_delay, output ready);
endinterface

interface ptd_rsp_if
	import ptd_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               task_found;
	logic [INDEX_W-1:0] chosen_index;
	logic [COUNT_W-1:0] ready_count;
	logic               period_elapsed;

	modport source (output valid, task_found, chosen_index, ready_count,
		period_elapsed, input ready);
	modport sink (input valid, task_found, chosen_index, ready_count,
		period_elapsed, output ready);
endinterface

`default_nettype wire

### sv/ptd_cell.sv
// ptd_cell: one task slot (enable, ready mark, period, delay) and its link in
// the dispatch priority chain. Depends on ptd_pkg.
`default_nettype none

module ptd_cell
	import ptd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ptd_cmd_t cmd,
	input  wire logic     load_sel,
	input  wire logic     taken_in,
	output logic          taken_out,
	output logic          pick,
	output logic          enabled,
	output logic          ready
);

	logic              en_q;
	logic              rdy_q;
	logic [BYTE_W-1:0] per_q;
	logic [BYTE_W-1:0] dly_q;
	logic              live;
	logic              count_en;

	assign live      = en_q & rdy_q;
	assign pick      = cmd.dispatch & live & ~taken_in;
	assign taken_out = taken_in | live;
	assign count_en  = cmd.fire & en_q & ~rdy_q;
	assign enabled   = en_q;
	assign ready     = rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			rdy_q <= 1'b0;
		end else if (load_sel) begin
			en_q  <= cmd.enable;
			rdy_q <= 1'b0;
		end else if (pick) begin
			rdy_q <= 1'b0;
			if (per_q == '0) begin
				en_q <= 1'b0;  // run-once task retires
			end
		end else if (count_en && dly_q == '0) begin
			rdy_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_sel) begin
			per_q <= cmd.period;
			dly_q <= cmd.delay;
		end else if (count_en) begin
			if (dly_q == '0) begin
				dly_q <= per_q - 8'd1;
			end else begin
				dly_q <= dly_q - 8'd1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/periodic_task_dispatcher_unit.sv
// periodic_task_dispatcher_unit: top level; prescaler, row of slot cells,
// ready counter and result register. Depends on ptd_pkg, ptd_if, ptd_cell.
//
//   port        dir   kind          contents
//   req         in    valid/ready   action, task_index, task_enable, task_period, start_delay
//   rsp         out   valid/ready   task_found, chosen_index, ready_count, period_elapsed
//   cfg_*       in    write only    tick_divisor
//
// At the accept edge the prescaler and every slot cell update at once and the
// item's own fields enter stage 1; when stage 1 drains, the ready marks are
// counted into the result register. The ready count over the cell row is the reason for this second register.
// An item can be accepted while the previous result still waits in rsp; a
// stalled rsp holds the counted item and blocks req until it drains.
// Reset (arst_n low) clears all slots, the prescaler and sets the divisor to 1.
`default_nettype none

module periodic_task_dispatcher_unit
	import ptd_pkg::*;
#(
	parameter int TASK_COUNT = DEF_TASKS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [DIV_W-1:0] cfg_wdata,
	ptd_req_if.sink               req,
	ptd_rsp_if.source             rsp
);

	// configuration and prescaler
	logic [DIV_W-1:0] div_q;
	logic [DIV_W-1:0] presc_q;
	logic [DIV_W-1:0] presc_nxt;
	logic             elapsed;

	// handshake and pipeline control
	logic accept;
	logic pend_s1;
	logic drain;
	logic out_valid_q;

	// cell row
	ptd_cmd_t              cmd;
	logic [TASK_COUNT:0]   taken;
	logic [TASK_COUNT-1:0] pick_vec;
	logic [TASK_COUNT-1:0] en_vec;
	logic [TASK_COUNT-1:0] rdy_vec;
	logic [INDEX_W-1:0]    pick_idx;

	// stage-1 result fields, waiting for the ready count
	logic               found_s1;
	logic [INDEX_W-1:0] chosen_s1;
	logic               elapsed_s1;

	// result register
	logic               found_q;
	logic [INDEX_W-1:0] chosen_q;
	logic [COUNT_W-1:0] count_q;
	logic               elapsed_q;

	assign accept    = req.valid & req.ready;
	assign req.ready = ~pend_s1;
	assign drain     = pend_s1 & (~out_valid_q | rsp.ready);

	// prescaler: incremented count reaching or passing the divisor ends a period
	assign presc_nxt = presc_q + 16'd1;
	assign elapsed   = (presc_nxt >= div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= DIV_RESET;
		end else if (cfg_we) begin
			div_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q <= '0;
		end else if (accept && req.action == ACT_TICK) begin
			presc_q <= elapsed ? '0 : presc_nxt;
		end
	end

	// broadcast command to all slots
	always_comb begin
		cmd.fire     = accept & (req.action == ACT_TICK) & elapsed;
		cmd.dispatch = accept & (req.action == ACT_DISPATCH);
		cmd.enable   = req.task_enable;
		cmd.period   = req.task_period;
		cmd.delay    = req.start_delay;
	end

	// slot row; the taken chain runs from slot 0 upward so the lowest ready wins
	assign taken[0] = 1'b0;

	for (genvar i = 0; i < TASK_COUNT; i++) begin : g_slot
		logic load_sel;
		if (i < INDEX_SLOTS) begin : g_addr
			assign load_sel = accept & (req.action == ACT_LOAD) &
				(req.task_index == INDEX_W'(i));
		end else begin : g_noaddr
			assign load_sel = 1'b0;  // beyond the 3-bit index range
		end

		ptd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.load_sel  (load_sel),
			.taken_in  (taken[i]),
			.taken_out (taken[i+1]),
			.pick      (pick_vec[i]),
			.enabled   (en_vec[i]),
			.ready     (rdy_vec[i])
		);
	end

	// at most one pick is high, so OR-ing the indexes encodes it
	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < TASK_COUNT; i++) begin
			if (pick_vec[i]) begin
				pick_idx = pick_idx | INDEX_W'(i);
			end
		end
	end

	// stage 1: hold the item's own fields until the slot row has settled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (accept) begin
			pend_s1 <= 1'b1;
		end else if (drain) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_s1   <= |pick_vec;
			chosen_s1  <= pick_idx;
			elapsed_s1 <= cmd.fire;
		end
	end

	// result register: count the ready marks left after the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			found_q   <= found_s1;
			chosen_q  <= chosen_s1;
			elapsed_q <= elapsed_s1;
			count_q   <= ready_sum(MAX_TASKS'(rdy_vec));
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.task_found     = found_q;
	assign rsp.chosen_index   = chosen_q;
	assign rsp.ready_count    = count_q;
	assign rsp.period_elapsed = elapsed_q;

`ifndef ASSERT_OFF
	a_one_pick: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pick_vec))
		else $error("more than one slot picked by dispatch");

	a_ready_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy_vec & ~en_vec) == '0)
		else $error("ready mark on a disabled slot");

	a_presc_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fire |=> presc_q == '0)
		else $error("prescaler not cleared after period end");

	a_pick_found: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.action == ACT_DISPATCH && taken[TASK_COUNT]) |=> found_s1)
		else $error("ready slot present but dispatch found none");
`endif

endmodule

`default_nettype wire

### tb/ptd_tb_pkg.sv
`timescale 1ns / 100ps
// ptd_tb_pkg: item and result types plus the dispatch scoreboard, which keeps its own
// copy of the slot table and prescaler and predicts one result per accepted item.
// Depends on ptd_pkg for widths and action codes.

package ptd_tb_pkg;
	import ptd_pkg::*;

	localparam int SLOTS = DEF_TASKS;
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;	// unused code, no state change
	localparam int MAX_PRINTS = 40;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [INDEX_W-1:0]  task_index;
		logic                task_enable;
		logic [BYTE_W-1:0]   task_period;
		logic [BYTE_W-1:0]   start_delay;
	} ptd_item_t;

	typedef struct packed {
		logic               task_found;
		logic [INDEX_W-1:0] chosen_index;
		logic [COUNT_W-1:0] ready_count;
		logic               period_elapsed;
	} ptd_result_t;

	class dispatch_scoreboard;
		bit              slot_on[SLOTS];
		bit              slot_rdy[SLOTS];
		bit [BYTE_W-1:0] slot_per[SLOTS];
		bit [BYTE_W-1:0] slot_dly[SLOTS];
		bit [DIV_W-1:0]  prescale;
		bit [DIV_W-1:0]  divisor;
		ptd_result_t     due_results[$];
		int              fail_count;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				slot_on[i]  = 1'b0;
				slot_rdy[i] = 1'b0;
				slot_per[i] = '0;
				slot_dly[i] = '0;
			end
			prescale   = '0;
			divisor    = DIV_RESET;
			fail_count = 0;
		endfunction

		function void set_divisor(bit [DIV_W-1:0] v);
			divisor = v;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// one raw tick; returns 1 when the scheduler period elapses
		function bit prescale_tick();
			bit [DIV_W-1:0] nxt;
			nxt = prescale + 1'b1;
			if (nxt < divisor) begin
				prescale = nxt;
				return 1'b0;
			end
			prescale = '0;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_on[i] && !slot_rdy[i]) begin
					if (slot_dly[i] == '0) begin
						slot_rdy[i] = 1'b1;
						slot_dly[i] = slot_per[i] - 1'b1;
					end else begin
						slot_dly[i] = slot_dly[i] - 1'b1;
					end
				end
			end
			return 1'b1;
		endfunction

		// applies one item to the table and returns the result it should produce
		function ptd_result_t dispatch_outcome(ptd_item_t it);
			ptd_result_t r;
			int n;
			r = '0;
			case (it.action)
				ACT_TICK: begin
					r.period_elapsed = prescale_tick();
				end
				ACT_DISPATCH: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_on[i] && slot_rdy[i]) begin
							r.task_found   = 1'b1;
							r.chosen_index = INDEX_W'(i);
							slot_rdy[i]    = 1'b0;
							if (slot_per[i] == '0) slot_on[i] = 1'b0;
							break;
						end
					end
				end
				ACT_LOAD: begin
					if (int'(it.task_index) < SLOTS) begin
						slot_on[it.task_index]  = it.task_enable;
						slot_rdy[it.task_index] = 1'b0;
						slot_per[it.task_index] = it.task_period;
						slot_dly[it.task_index] = it.start_delay;
					end
				end
				default: ;
			endcase
			n = 0;
			for (int i = 0; i < SLOTS; i++) n += slot_rdy[i];
			r.ready_count = (n > int'(COUNT_SAT)) ? COUNT_SAT : COUNT_W'(n);
			return r;
		endfunction

		function void note_request(ptd_item_t it);
			due_results.push_back(dispatch_outcome(it));
		endfunction

		task report(string msg);
			fail_count++;
			if (fail_count <= MAX_PRINTS) $display("%0t MISMATCH %s", $realtime, msg);
		endtask

		task check_result(ptd_result_t got);
			ptd_result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			want = due_results.pop_front();
			if (got.task_found !== want.task_found)
				report($sformatf("task_found got %b want %b", got.task_found,
					want.task_found));
			if (got.chosen_index !== want.chosen_index)
				report($sformatf("chosen_index got %0d want %0d", got.chosen_index,
					want.chosen_index));
			if (got.ready_count !== want.ready_count)
				report($sformatf("ready_count got %0d want %0d", got.ready_count,
					want.ready_count));
			if (got.period_elapsed !== want.period_elapsed)
				report($sformatf("period_elapsed got %b want %b", got.period_elapsed,
					want.period_elapsed));
		endtask
	endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: drives the periodic task dispatcher with directed and random items,
// random idling on both channels and divisor changes. Depends on ptd_pkg, ptd_if, ptd_tb_pkg.

module tb_top;
	import ptd_pkg::*;
	import ptd_tb_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [DIV_W-1:0] cfg_wdata;

	ptd_req_if req_ch ();
	ptd_rsp_if rsp_ch ();

	periodic_task_dispatcher_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	dispatch_scoreboard sb = new();

	// shared knobs: no_idle turns off random idling on both sides,
	// hold_left makes the receiver refuse results until it counts down to zero
	bit no_idle   = 1'b0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// safety net against a hung handshake
	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result side: checks every accepted item, then picks ready for the
	// next cycle. Values are sampled at the edge before any update lands.
	// ---------------------------------------------------------------
	initial begin
		ptd_result_t got;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.task_found     = rsp_ch.task_found;
				got.chosen_index   = rsp_ch.chosen_index;
				got.ready_count    = rsp_ch.ready_count;
				got.period_elapsed = rsp_ch.period_elapsed;
				sb.check_result(got);
			end
			if (hold_left > 0) begin
				// long stall: the block fills up and must push back on req
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= no_idle || ($urandom_range(99) >= 38);
			end
		end
	end

	function automatic ptd_item_t mk_item(logic [ACTION_W-1:0] act, int idx, bit en,
			int per, int dly);
		ptd_item_t it;
		it.action      = act;
		it.task_index  = INDEX_W'(idx);
		it.task_enable = en;
		it.task_period = BYTE_W'(per);
		it.start_delay = BYTE_W'(dly);
		return it;
	endfunction

	// Mostly well-formed traffic: ticks, dispatches and loads of enabled
	// tasks with short periods so slots actually reach ready. A few loads
	// use the full field range, and a few items carry the spare code.
	function automatic ptd_item_t random_item();
		ptd_item_t it;
		int pick;
		pick = $urandom_range(99);
		it.task_index  = INDEX_W'($urandom_range(7));
		it.task_enable = 1'($urandom_range(1));
		it.task_period = BYTE_W'($urandom_range(255));
		it.start_delay = BYTE_W'($urandom_range(255));
		if (pick < 45) begin
			it.action = ACT_TICK;
		end else if (pick < 70) begin
			it.action = ACT_DISPATCH;
		end else if (pick < 97) begin
			it.action = ACT_LOAD;
			if ($urandom_range(4) != 0) begin
				it.task_enable = ($urandom_range(9) != 0);
				it.task_period = BYTE_W'($urandom_range(4));
				it.start_delay = BYTE_W'($urandom_range(3));
			end
		end else begin
			it.action = ACT_SPARE;
		end
		return it;
	endfunction

	// Offers one item and returns at the edge that accepts it. Valid stays
	// high so a back-to-back item only rewrites the payload.
	task automatic send_item(ptd_item_t it);
		req_ch.valid       <= 1'b1;
		req_ch.action      <= it.action;
		req_ch.task_index  <= it.task_index;
		req_ch.task_enable <= it.task_enable;
		req_ch.task_period <= it.task_period;
		req_ch.start_delay <= it.start_delay;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(it);
	endtask

	// random sender gaps: each further idle cycle is drawn with a 38 percent chance
	task automatic sender_gap();
		if (!no_idle) begin
			while ($urandom_range(99) < 38) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	task automatic send_gapped(ptd_item_t it);
		send_item(it);
		sender_gap();
	endtask

	// sender pause until every predicted result has been checked
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// divisor writes only happen with the block empty
	task automatic write_divisor(logic [DIV_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_divisor(v);
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		logic [DIV_W-1:0] phase_div[7];
		int               phase_len[7];
		ptd_item_t        directed[$];

		phase_div = '{16'd0, 16'd3, 16'd65535, 16'd5, 16'd2, 16'd1, 16'd17};
		phase_len = '{150, 160, 60, 160, 160, 160, 160};

		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		req_ch.valid       <= 1'b0;
		req_ch.action      <= ACT_TICK;
		req_ch.task_index  <= '0;
		req_ch.task_enable <= 1'b0;
		req_ch.task_period <= '0;
		req_ch.start_delay <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed run at the reset divisor of 1 (every tick elapses)
		directed.push_back(mk_item(ACT_DISPATCH, 0, 0, 0, 0));     // nothing ready
		directed.push_back(mk_item(ACT_SPARE, 7, 1, 255, 255));    // spare code
		directed.push_back(mk_item(ACT_LOAD, 0, 1, 0, 0));         // run-once task
		directed.push_back(mk_item(ACT_LOAD, 7, 1, 255, 255));     // field maxima
		directed.push_back(mk_item(ACT_LOAD, 3, 0, 5, 0));         // removed, still written
		directed.push_back(mk_item(ACT_LOAD, 1, 1, 1, 1));
		directed.push_back(mk_item(ACT_TICK, 0, 0, 0, 0));         // slot 0 ready
		directed.push_back(mk_item(ACT_TICK, 7, 1, 255, 255));     // slot 1 ready
		directed.push_back(mk_item(ACT_LOAD, 1, 1, 2, 0));         // reload clears ready
		directed.push_back(mk_item(ACT_DISPATCH, 0, 0, 0, 0));     // slot 0, then disabled
		directed.push_back(mk_item(ACT_TICK, 0, 0, 0, 0));
		directed.push_back(mk_item(ACT_DISPATCH, 0, 0, 0, 0));     // slot 1
		directed.push_back(mk_item(ACT_DISPATCH, 0, 0, 0, 0));     // empty again
		for (int i = 2; i < 7; i++) directed.push_back(mk_item(ACT_LOAD, i, 1, i - 2, 0));
		directed.push_back(mk_item(ACT_TICK, 0, 0, 0, 0));         // many ready at once
		directed.push_back(mk_item(ACT_DISPATCH, 0, 0, 0, 0));     // lowest index wins
		directed.push_back(mk_item(ACT_DISPATCH, 0, 0, 0, 0));
		directed.push_back(mk_item(ACT_TICK, 0, 0, 0, 0));         // ready slots hold delay
		directed.push_back(mk_item(ACT_DISPATCH, 0, 0, 0, 0));
		directed.push_back(mk_item(ACT_LOAD, 4, 0, 0, 0));         // remove a ready slot
		foreach (directed[i]) send_gapped(directed[i]);

		// Random phases, each with its own divisor. The 65535 phase leaves the
		// prescaler high, so the next, smaller divisor fires on the first tick.
		foreach (phase_div[p]) begin
			write_divisor(phase_div[p]);
			no_idle = (p == 1);
			if (p == 3) hold_left = 400;
			for (int k = 0; k < phase_len[p]; k++) begin
				if (k == phase_len[p] / 2 && p == 4) drain();
				send_gapped(random_item());
			end
		end
		no_idle = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0) sb.report($sformatf("%0d results never came", sb.pending()));
		if (sb.fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### sim.f
sv/ptd_pkg.sv
sv/ptd_if.sv
sv/ptd_cell.sv
sv/periodic_task_dispatcher_unit.sv
tb/ptd_tb_pkg.sv
tb/tb_top.sv
